// ===== hw/rtl/inactivity_lock_timer_macros.svh =====
// ----------------------------------------------------------------------------
// Inactivity lock timer assertion macros
// Shared concurrent assertion forms, clocked on clk, disabled in reset.
// ----------------------------------------------------------------------------
`ifndef INACTIVITY_LOCK_TIMER_MACROS_SVH
`define INACTIVITY_LOCK_TIMER_MACROS_SVH

// same-cycle implication
`define ILT_ASSERT_IMPLY(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("inactivity lock timer assertion failed");

// next-cycle implication
`define ILT_ASSERT_NEXT(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("inactivity lock timer assertion failed");

`endif

// ===== hw/rtl/ilt_pkg.sv =====
// ----------------------------------------------------------------------------
// Inactivity lock timer package
// Widths, reset values, word kinds, register map and configuration struct.
// ----------------------------------------------------------------------------
package ilt_pkg;

  localparam int SecW   = 17;
  localparam int CoordW = 16;
  localparam int MaskW  = 5;
  localparam int ThrW   = 8;
  localparam int KindW  = 4;
  localparam int AddrW  = 4;
  localparam int DataW  = 32;

  localparam logic [SecW-1:0]   TIMEOUT_RESET   = SecW'(20 * 60);
  localparam logic [SecW-1:0]   SUSPEND_RESET   = SecW'(3 * 60 * 60);
  localparam logic [MaskW-1:0]  MASK_RESET      = MaskW'(31);
  localparam logic [ThrW-1:0]   THRESH_RESET    = ThrW'(20);
  localparam logic [2*ThrW-1:0] THRESH_SQ_RESET = (2*ThrW)'(20 * 20);
  localparam logic [SecW-1:0]   LOCK_SOON_SECS  = SecW'(10);

  typedef enum logic [KindW-1:0] {
    KIND_TICK        = 4'd0,
    KIND_KEY_DOWN    = 4'd1,
    KIND_MOUSE_BTN   = 4'd2,
    KIND_POINTER     = 4'd3,
    KIND_PAD_BTN     = 4'd4,
    KIND_PAD_AXIS    = 4'd5,
    KIND_PAD_CONNECT = 4'd6,
    KIND_LOCK_SOON   = 4'd7,
    KIND_TOGGLE      = 4'd8,
    KIND_LOCK_NOW    = 4'd9
  } kind_t;

  typedef enum logic [1:0] {
    REG_TIMEOUT   = 2'd0,
    REG_SUSPEND   = 2'd1,
    REG_MASK      = 2'd2,
    REG_THRESHOLD = 2'd3
  } reg_idx_t;

  localparam int MASK_KEY     = 0;
  localparam int MASK_MOUSE   = 1;
  localparam int MASK_POINTER = 2;
  localparam int MASK_PAD_BTN = 3;
  localparam int MASK_PAD_AX  = 4;

  typedef struct packed {
    logic [SecW-1:0]   timeout;
    logic [SecW-1:0]   suspend_limit;
    logic [MaskW-1:0]  detect_mask;
    logic [ThrW-1:0]   move_threshold;
    logic [2*ThrW-1:0] threshold_sq;
  } cfg_t;

endpackage

// ===== hw/rtl/inactivity_lock_timer.sv =====
// ----------------------------------------------------------------------------
// Inactivity lock timer
// Watchdog that raises a one-word lock pulse after a timeout with no activity, or on a lock-now word.
// Path: input register, then result register.
// Throughput: 1 word per cycle unless the output is stalled; the state update,
// pointer distance included, is combinational after the input register.
// Reset: synchronous; state, configuration and valids return to their reset values.
// ----------------------------------------------------------------------------
module inactivity_lock_timer (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              in_valid,
  output logic                              in_stall,
  input  logic [ilt_pkg::KindW-1:0]         kind,
  input  logic signed [ilt_pkg::CoordW-1:0] pointer_x,
  input  logic signed [ilt_pkg::CoordW-1:0] pointer_y,
  input  logic                              confirmed,
  output logic                              out_valid,
  input  logic                              out_stall,
  output logic                              lock,
  output logic                              enabled,
  output logic [ilt_pkg::SecW-1:0]          remaining_seconds,
  input  logic                              psel,
  input  logic                              penable,
  input  logic                              pwrite,
  input  logic [ilt_pkg::AddrW-1:0]         paddr,
  input  logic [ilt_pkg::DataW-1:0]         pwdata,
  output logic [ilt_pkg::DataW-1:0]         prdata,
  output logic                              pready
);

  localparam int SecW   = ilt_pkg::SecW;
  localparam int CoordW = ilt_pkg::CoordW;

  ilt_pkg::cfg_t cfg;

  ilt_regs u_regs (
    .clk     (clk),
    .rst     (rst),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg     (cfg)
  );

  // input register
  logic                      in_q_valid;
  logic [ilt_pkg::KindW-1:0] in_kind;
  logic [CoordW-1:0]         in_x;
  logic [CoordW-1:0]         in_y;
  logic                      in_conf;

  // state
  logic [SecW-1:0]   countdown, countdown_next;
  logic [SecW-1:0]   suspend_count, suspend_count_next;
  logic              active, active_next;
  logic [CoordW-1:0] last_x, last_x_next;
  logic [CoordW-1:0] last_y, last_y_next;
  logic              lock_next;

  logic advance;
  logic fire;

  assign advance  = !out_valid || !out_stall;
  assign fire     = in_q_valid && advance;
  assign in_stall = in_q_valid && !advance;

  always_ff @(posedge clk) begin
    if (rst) begin
      in_q_valid <= 1'b0;
    end else if (!in_stall) begin
      in_q_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (!in_stall && in_valid) begin
      in_kind <= kind;
      in_x    <= pointer_x;
      in_y    <= pointer_y;
      in_conf <= confirmed;
    end
  end

  // tick arithmetic
  logic [SecW-1:0] cd_tick;
  logic [SecW-1:0] sc_tick;
  logic            act_tick;

  assign cd_tick  = (active && countdown != '0) ? countdown - SecW'(1) : countdown;
  assign sc_tick  = (!active && suspend_count != '0) ? suspend_count - SecW'(1)
                                                      : suspend_count;
  assign act_tick = active || (sc_tick == '0);

  // pointer distance
  logic signed [CoordW:0] dx, dy;
  logic [CoordW-1:0]      adx, ady;
  logic [2*CoordW-1:0]    sqx, sqy;
  logic [2*CoordW:0]      d2;
  logic                   moved;

  assign dx    = {in_x[CoordW-1], in_x} - {last_x[CoordW-1], last_x};
  assign dy    = {in_y[CoordW-1], in_y} - {last_y[CoordW-1], last_y};
  assign adx   = dx[CoordW] ? CoordW'(-dx) : dx[CoordW-1:0];
  assign ady   = dy[CoordW] ? CoordW'(-dy) : dy[CoordW-1:0];
  assign sqx   = (2*CoordW)'(adx) * (2*CoordW)'(adx);
  assign sqy   = (2*CoordW)'(ady) * (2*CoordW)'(ady);
  assign d2    = {1'b0, sqx} + {1'b0, sqy};
  assign moved = d2 > (2*CoordW+1)'(cfg.threshold_sq);

  always_comb begin
    countdown_next     = countdown;
    suspend_count_next = suspend_count;
    active_next        = active;
    last_x_next        = last_x;
    last_y_next        = last_y;
    lock_next          = 1'b0;
    case (in_kind)
      ilt_pkg::KIND_TICK: begin
        suspend_count_next = sc_tick;
        active_next        = act_tick;
        if (cd_tick == '0) begin
          lock_next      = 1'b1;
          countdown_next = cfg.timeout;
        end else begin
          countdown_next = cd_tick;
        end
      end
      ilt_pkg::KIND_KEY_DOWN: begin
        if (cfg.detect_mask[ilt_pkg::MASK_KEY]) countdown_next = cfg.timeout;
      end
      ilt_pkg::KIND_MOUSE_BTN: begin
        if (cfg.detect_mask[ilt_pkg::MASK_MOUSE]) countdown_next = cfg.timeout;
      end
      ilt_pkg::KIND_POINTER: begin
        if (cfg.detect_mask[ilt_pkg::MASK_POINTER] && moved) begin
          last_x_next    = in_x;
          last_y_next    = in_y;
          countdown_next = cfg.timeout;
        end
      end
      ilt_pkg::KIND_PAD_BTN: begin
        if (cfg.detect_mask[ilt_pkg::MASK_PAD_BTN]) countdown_next = cfg.timeout;
      end
      ilt_pkg::KIND_PAD_AXIS: begin
        if (cfg.detect_mask[ilt_pkg::MASK_PAD_AX]) countdown_next = cfg.timeout;
      end
      ilt_pkg::KIND_PAD_CONNECT: begin
        if (cfg.detect_mask[ilt_pkg::MASK_PAD_BTN] || cfg.detect_mask[ilt_pkg::MASK_PAD_AX]) begin
          countdown_next = cfg.timeout;
        end
      end
      ilt_pkg::KIND_LOCK_SOON: begin
        active_next    = 1'b1;
        countdown_next = ilt_pkg::LOCK_SOON_SECS;
      end
      ilt_pkg::KIND_TOGGLE: begin
        if (!active) begin
          active_next = 1'b1;
        end else if (in_conf) begin
          suspend_count_next = cfg.suspend_limit;
          active_next        = 1'b0;
        end
      end
      ilt_pkg::KIND_LOCK_NOW: begin
        active_next = 1'b1;
        lock_next   = 1'b1;
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      countdown     <= ilt_pkg::TIMEOUT_RESET;
      suspend_count <= ilt_pkg::SUSPEND_RESET;
      active        <= 1'b1;
      last_x        <= '0;
      last_y        <= '0;
    end else if (fire) begin
      countdown     <= countdown_next;
      suspend_count <= suspend_count_next;
      active        <= active_next;
      last_x        <= last_x_next;
      last_y        <= last_y_next;
    end
  end

  // result register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (advance) begin
      out_valid <= in_q_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (fire) begin
      lock              <= lock_next;
      enabled           <= active_next;
      remaining_seconds <= countdown_next;
    end
  end

endmodule

// ===== hw/rtl/ilt_regs.sv =====
// ----------------------------------------------------------------------------
// Inactivity lock timer register file
// APB-style configuration registers; keeps the squared move threshold too.
// ----------------------------------------------------------------------------
module ilt_regs (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        psel,
  input  logic                        penable,
  input  logic                        pwrite,
  input  logic [ilt_pkg::AddrW-1:0]   paddr,
  input  logic [ilt_pkg::DataW-1:0]   pwdata,
  output logic [ilt_pkg::DataW-1:0]   prdata,
  output logic                        pready,
  output ilt_pkg::cfg_t               cfg
);

  logic                       wr;
  logic [1:0]                 idx;
  logic [ilt_pkg::ThrW-1:0]   wthr;

  assign pready = 1'b1;
  assign wr     = psel & penable & pwrite;
  assign idx    = paddr[3:2];
  assign wthr   = pwdata[ilt_pkg::ThrW-1:0];

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.timeout        <= ilt_pkg::TIMEOUT_RESET;
      cfg.suspend_limit  <= ilt_pkg::SUSPEND_RESET;
      cfg.detect_mask    <= ilt_pkg::MASK_RESET;
      cfg.move_threshold <= ilt_pkg::THRESH_RESET;
      cfg.threshold_sq   <= ilt_pkg::THRESH_SQ_RESET;
    end else if (wr) begin
      case (idx)
        ilt_pkg::REG_TIMEOUT: begin
          cfg.timeout <= pwdata[ilt_pkg::SecW-1:0];
        end
        ilt_pkg::REG_SUSPEND: begin
          cfg.suspend_limit <= pwdata[ilt_pkg::SecW-1:0];
        end
        ilt_pkg::REG_MASK: begin
          cfg.detect_mask <= pwdata[ilt_pkg::MaskW-1:0];
        end
        ilt_pkg::REG_THRESHOLD: begin
          cfg.move_threshold <= wthr;
          cfg.threshold_sq   <= (2*ilt_pkg::ThrW)'(wthr) * (2*ilt_pkg::ThrW)'(wthr);
        end
        default: begin
        end
      endcase
    end
  end

  always_comb begin
    case (idx)
      ilt_pkg::REG_TIMEOUT:   prdata = ilt_pkg::DataW'(cfg.timeout);
      ilt_pkg::REG_SUSPEND:   prdata = ilt_pkg::DataW'(cfg.suspend_limit);
      ilt_pkg::REG_MASK:      prdata = ilt_pkg::DataW'(cfg.detect_mask);
      ilt_pkg::REG_THRESHOLD: prdata = ilt_pkg::DataW'(cfg.move_threshold);
      default:                prdata = '0;
    endcase
  end

endmodule

// ===== hw/rtl/ilt_checker.sv =====
// ----------------------------------------------------------------------------
// Inactivity lock timer checker
// Port-level assertions, bound to the top level.
// ----------------------------------------------------------------------------
`include "inactivity_lock_timer_macros.svh"

module ilt_checker (
  input logic                       clk,
  input logic                       rst,
  input logic                       in_valid,
  input logic                       in_stall,
  input logic                       out_valid,
  input logic                       out_stall,
  input logic                       lock,
  input logic                       enabled,
  input logic [ilt_pkg::SecW-1:0]   remaining_seconds
);

  // a stalled result word holds
  `ILT_ASSERT_NEXT(a_out_hold, clk, rst, out_valid && out_stall, out_valid && $stable(lock) && $stable(enabled) && $stable(remaining_seconds))

  // an accepted word shows up as a result after the input and result registers
  `ILT_ASSERT_IMPLY(a_latency, clk, rst, in_valid && !in_stall, ##2 out_valid)

  // nothing comes out straight after reset
  `ILT_ASSERT_IMPLY(a_reset_empty, clk, rst, $past(rst), !out_valid)

endmodule

bind inactivity_lock_timer ilt_checker u_ilt_checker (.*);
